// File: design/lidar_ray_ground_classifier_unit_defines.svh
// Assertion macros used by the top-level design file.
// LRGC_ASSERT expects signals named clk and rst_n, LRGC_ASSERT_ALWAYS only clk, in the scope where it is used.
`ifndef LIDAR_RAY_GROUND_CLASSIFIER_UNIT_DEFINES_SVH
`define LIDAR_RAY_GROUND_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTH

`define LRGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LRGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LRGC_ASSERT(lbl, prop, msg)

`define LRGC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: design/lrgc_pkg.sv
package lrgc_pkg;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned Q_BITS   = 14;
  localparam int unsigned IDX_W    = 17;

  localparam logic [2:0] REG_LOCAL_SLOPE   = 3'd0;
  localparam logic [2:0] REG_GENERAL_SLOPE = 3'd1;
  localparam logic [2:0] REG_MOUNT_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_MIN_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_CONCENTRIC    = 3'd4;
  localparam logic [2:0] REG_RECLASS       = 3'd5;

  localparam logic [15:0] RST_LOCAL_SLOPE   = 16'd2303;
  localparam logic [15:0] RST_GENERAL_SLOPE = 16'd1433;
  localparam logic [15:0] RST_MOUNT_HEIGHT  = 16'd880;
  localparam logic [15:0] RST_MIN_HEIGHT    = 16'd26;
  localparam logic [15:0] RST_CONCENTRIC    = 16'd5;
  localparam logic [15:0] RST_RECLASS       = 16'd102;

  typedef struct packed {
    logic [15:0]        radius;
    logic signed [15:0] height;
    logic               ray_start;
    logic [IDX_W-1:0]   point_index;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             is_ground;
  } out_t;

  typedef struct packed {
    logic [15:0] local_slope_tan;
    logic [15:0] general_slope_tan;
    logic [15:0] mount_height;
    logic [15:0] min_height_threshold;
    logic [15:0] concentric_distance;
    logic [15:0] reclass_distance;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        radius;
    logic signed [16:0] height;
    logic               was_ground;
  } ray_state_t;

endpackage

// File: design/lrgc_regs.sv
module lrgc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrgc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lrgc_pkg::DATA_W-1:0]  pwdata,
  output logic [lrgc_pkg::DATA_W-1:0]  prdata,
  output lrgc_pkg::cfg_t               cfg
);

  lrgc_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_slope_tan      <= lrgc_pkg::RST_LOCAL_SLOPE;
      cfg_r.general_slope_tan    <= lrgc_pkg::RST_GENERAL_SLOPE;
      cfg_r.mount_height         <= lrgc_pkg::RST_MOUNT_HEIGHT;
      cfg_r.min_height_threshold <= lrgc_pkg::RST_MIN_HEIGHT;
      cfg_r.concentric_distance  <= lrgc_pkg::RST_CONCENTRIC;
      cfg_r.reclass_distance     <= lrgc_pkg::RST_RECLASS;
    end else if (wr_en) begin
      unique case (reg_idx)
        lrgc_pkg::REG_LOCAL_SLOPE:   cfg_r.local_slope_tan      <= pwdata[15:0];
        lrgc_pkg::REG_GENERAL_SLOPE: cfg_r.general_slope_tan    <= pwdata[15:0];
        lrgc_pkg::REG_MOUNT_HEIGHT:  cfg_r.mount_height         <= pwdata[15:0];
        lrgc_pkg::REG_MIN_HEIGHT:    cfg_r.min_height_threshold <= pwdata[15:0];
        lrgc_pkg::REG_CONCENTRIC:    cfg_r.concentric_distance  <= pwdata[15:0];
        lrgc_pkg::REG_RECLASS:       cfg_r.reclass_distance     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lrgc_pkg::REG_LOCAL_SLOPE:   prdata = {16'd0, cfg_r.local_slope_tan};
      lrgc_pkg::REG_GENERAL_SLOPE: prdata = {16'd0, cfg_r.general_slope_tan};
      lrgc_pkg::REG_MOUNT_HEIGHT:  prdata = {16'd0, cfg_r.mount_height};
      lrgc_pkg::REG_MIN_HEIGHT:    prdata = {16'd0, cfg_r.min_height_threshold};
      lrgc_pkg::REG_CONCENTRIC:    prdata = {16'd0, cfg_r.concentric_distance};
      lrgc_pkg::REG_RECLASS:       prdata = {16'd0, cfg_r.reclass_distance};
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: design/lrgc_slope.sv
module lrgc_slope (
  input  lrgc_pkg::cfg_t       cfg,
  input  lrgc_pkg::in_t        pt,
  input  lrgc_pkg::ray_state_t last,
  output lrgc_pkg::ray_state_t state_nxt,
  output logic                 is_ground
);

  logic [15:0]        eff_radius;
  logic signed [16:0] eff_height;
  logic               eff_ground;
  logic signed [16:0] ground_ref;
  logic [15:0]        step;
  logic [31:0]        local_prod;
  logic [31:0]        general_band;
  logic [31:0]        height_floor;
  logic [31:0]        local_band;
  logic [17:0]        diff_local;
  logic [17:0]        diff_ref;
  logic [16:0]        abs_local;
  logic [16:0]        abs_ref;
  logic [31:0]        scaled_local;
  logic [31:0]        scaled_ref;
  logic               local_ok;
  logic               ref_local_ok;
  logic               ref_general_ok;

  // A ray start restarts the ray at the origin, on the ground plane below the sensor.
  assign ground_ref = 17'sd0 - $signed({1'b0, cfg.mount_height});
  assign eff_radius = pt.ray_start ? 16'd0 : last.radius;
  assign eff_height = pt.ray_start ? ground_ref : last.height;
  assign eff_ground = pt.ray_start ? 1'b0 : last.was_ground;

  assign step         = (pt.radius > eff_radius) ? (pt.radius - eff_radius) : 16'd0;
  assign local_prod   = 32'(cfg.local_slope_tan) * 32'(step);
  assign general_band = 32'(cfg.general_slope_tan) * 32'(pt.radius);
  assign height_floor = {2'b00, cfg.min_height_threshold, 14'd0};
  assign local_band   = ((step > cfg.concentric_distance) && (local_prod < height_floor))
                        ? height_floor : local_prod;

  assign diff_local = {{2{pt.height[15]}}, pt.height} - {eff_height[16], eff_height};
  assign diff_ref   = {{2{pt.height[15]}}, pt.height} + {2'b00, cfg.mount_height};
  assign abs_local  = diff_local[17] ? 17'(18'd0 - diff_local) : diff_local[16:0];
  assign abs_ref    = diff_ref[17] ? 17'(18'd0 - diff_ref) : diff_ref[16:0];

  assign scaled_local = {1'b0, abs_local, 14'd0};
  assign scaled_ref   = {1'b0, abs_ref, 14'd0};

  assign local_ok       = scaled_local <= local_band;
  assign ref_local_ok   = scaled_ref <= local_band;
  assign ref_general_ok = scaled_ref <= general_band;

  always_comb begin
    if (local_ok) begin
      is_ground = eff_ground || ref_general_ok;
    end else begin
      is_ground = (step > cfg.reclass_distance) && ref_local_ok;
    end
  end

  assign state_nxt.radius     = pt.radius;
  assign state_nxt.height     = {pt.height[15], pt.height};
  assign state_nxt.was_ground = is_ground;

endmodule

// File: design/lidar_ray_ground_classifier_unit.sv
// Ground classifier for LiDAR points streamed one ray at a time, sorted by radius.
// It accepts one point transaction per clock cycle while the output side is not stalled.
// An accepted point waits in the input register until the result register can take it;
// between the two lies the combinational classification path: radial step, the two
// 16 by 16 slope multiplies and the band compares, whose ground flag is fed back to the
// next point of the ray.
`include "lidar_ray_ground_classifier_unit_defines.svh"

module lidar_ray_ground_classifier_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lrgc_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lrgc_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrgc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lrgc_pkg::DATA_W-1:0]  pwdata,
  output logic [lrgc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  lrgc_pkg::cfg_t       cfg;
  lrgc_pkg::in_t        s1_r;
  logic                 s1_valid_r;
  lrgc_pkg::out_t       out_r;
  logic                 out_valid_r;
  lrgc_pkg::ray_state_t state_r;
  lrgc_pkg::ray_state_t state_nxt;
  logic                 ground;
  logic                 advance;

  assign pready = 1'b1;

  lrgc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lrgc_slope u_slope (
    .cfg       (cfg),
    .pt        (s1_r),
    .last      (state_r),
    .state_nxt (state_nxt),
    .is_ground (ground)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r.result_index <= s1_r.point_index;
      out_r.is_ground    <= ground;
    end
  end

  `LRGC_ASSERT(a_s1_holds, (s1_valid_r && !advance) |=> s1_valid_r, "Stalled point was dropped")
  `LRGC_ASSERT(a_out_from_advance, $rose(out_valid_r) |-> $past(advance), "Result without point")
  `LRGC_ASSERT(a_state_update, advance |=> (state_r.radius == $past(s1_r.radius)), "State not updated")
  `LRGC_ASSERT(a_index_pass, advance |=> (out_r.result_index == $past(s1_r.point_index)), "Index lost")
  `LRGC_ASSERT_ALWAYS(a_empty_ready, (rst_n && !out_valid_r) |-> in_ready, "Idle block not ready")

endmodule
